/* hdl/tpc_pkg.sv */
package tpc_pkg;

  localparam int NODES      = 1024;
  localparam int ALPHABET   = 62;
  localparam int COUNT_BITS = 16;

  localparam int NODE_W      = $clog2(NODES);
  localparam int FREE_W      = NODE_W + 1;
  localparam int SLOTS       = NODES * ALPHABET;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int SYM_W       = $clog2(ALPHABET);
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int OUT_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int EXT_W       = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_EXACT  = 2'd1;

  localparam logic [CHAR_W-1:0] CH_LO_A = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LO_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CH_UP_A = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UP_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CH_D0   = 8'd48;
  localparam logic [CHAR_W-1:0] CH_D9   = 8'd57;
  localparam logic [CHAR_W-1:0] UP_BASE = 8'd26;
  localparam logic [CHAR_W-1:0] DG_BASE = 8'd52;

  typedef enum logic [1:0] {
    ST_OK,
    ST_POOL_FULL,
    ST_BAD_CHAR
  } status_e;

  typedef enum logic [1:0] {
    FL_NONE,
    FL_POOL_FULL,
    FL_BAD_CHAR,
    FL_MISS
  } flag_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_PINC,
    S_FREAD,
    S_FRES
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic decide;
    logic pinc;
    logic fread;
    logic fres;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic char_ok;
    logic go_pinc;
    logic last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] idx;
  } sym_t;

  function automatic sym_t sym_of(logic [CHAR_W-1:0] ch);
    sym_t s;
    s.ok  = 1'b1;
    s.idx = '0;
    if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
      s.idx = SYM_W'(ch - CH_LO_A);
    end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
      s.idx = SYM_W'(ch - CH_UP_A + UP_BASE);
    end else if (ch >= CH_D0 && ch <= CH_D9) begin
      s.idx = SYM_W'(ch - CH_D0 + DG_BASE);
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] to_out(logic [COUNT_BITS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'({OUT_W{1'b1}})) begin
      return '1;
    end
    return OUT_W'(e);
  endfunction

endpackage

/* hdl/trie_word_prefix_counter.sv */
// per character the controller steps through S_IDLE and S_LOOKUP when the word is already flagged
// or the character is invalid, adds S_DECIDE for a search step and S_DECIDE then S_PINC for an insert
// step (child table read, then pass count update); the last character adds S_FREAD for the count read
// and S_FRES to load the result register, which waits until that register is free
// one character in flight at a time; after reset a clearing pass over all NODES*ALPHABET (63488)
// child slots zeroes the trie memories, with s_axis_tready low until it ends
module trie_word_prefix_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // operation, char_code
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // count, status
);
  import tpc_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [OUT_W-1:0]    count;
  logic [STATUS_W-1:0] status;

  tpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tdata[OP_W-1:0]),
    .char_i      (s_axis_tdata[OP_W+CHAR_W-1:OP_W]),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .count_o     (count),
    .status_o    (status)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W - STATUS_W){1'b0}}, status, count};

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_one_char_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second character taken while one is in flight");

  a_error_has_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_POOL_FULL || status == ST_BAD_CHAR) |-> count == '0)
    else $error("flagged word carries a count");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fres |-> sts.out_free)
    else $error("result register overwritten");

endmodule

/* hdl/tpc_ctrl.sv */
module tpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tpc_pkg::sts_t sts_i,
  output tpc_pkg::cmd_t cmd_o
);
  import tpc_pkg::*;

  state_e state_q, state_d;
  state_e char_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    char_end   = sts_i.last ? S_FREAD : S_IDLE;
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d = sts_i.char_ok ? S_DECIDE : char_end;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = sts_i.go_pinc ? S_PINC : char_end;
      end
      S_PINC: begin
        cmd_o.pinc = 1'b1;
        state_d = char_end;
      end
      S_FREAD: begin
        cmd_o.fread = 1'b1;
        state_d = S_FRES;
      end
      S_FRES: begin
        if (sts_i.out_free) begin
          cmd_o.fres = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

/* hdl/tpc_dp.sv */
module tpc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpc_pkg::cmd_t                    cmd_i,
  output tpc_pkg::sts_t                    sts_o,
  input  logic [tpc_pkg::OP_W-1:0]         op_i,
  input  logic [tpc_pkg::CHAR_W-1:0]       char_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tpc_pkg::OUT_W-1:0]        count_o,
  output logic [tpc_pkg::STATUS_W-1:0]     status_o
);
  import tpc_pkg::*;

  logic [NODE_W-1:0]     child_mem [SLOTS];
  logic [COUNT_BITS-1:0] end_mem   [NODES];
  logic [COUNT_BITS-1:0] pass_mem  [NODES];

  logic [NODE_W-1:0]     child_rd_q;
  logic [COUNT_BITS-1:0] end_rd_q, pass_rd_q;

  logic [OP_W-1:0]   op_q;
  logic              start_q;
  flag_e             flags_q;
  logic [NODE_W-1:0] cursor_q;
  logic [FREE_W-1:0] next_free_q;
  logic [SLOT_W-1:0] clr_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SYM_W-1:0]  sym_q;
  logic              sym_ok_q;
  logic              last_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  count_q;
  status_e           status_q;

  sym_t              sym_in;
  logic [SLOT_W-1:0] slot;
  logic              is_ins, child_zero, pool_full, go_pinc, clr_cnt;
  logic [NODE_W-1:0] new_node;

  logic              child_we;
  logic [SLOT_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic              pass_re, pass_we, end_we;
  logic [NODE_W-1:0] pass_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] pass_wdata, end_wdata;
  logic [OUT_W-1:0]  res_count;
  status_e           res_status;

  always_comb begin
    sym_in     = sym_of(char_i);
    slot       = SLOT_W'(cursor_q) * SLOT_W'(ALPHABET) + SLOT_W'(sym_q);
    is_ins     = (op_q == OP_INSERT);
    child_zero = (child_rd_q == '0);
    pool_full  = (next_free_q >= FREE_W'(NODES));
    go_pinc    = is_ins && !(child_zero && pool_full);
    new_node   = child_zero ? next_free_q[NODE_W-1:0] : child_rd_q;
    clr_cnt    = cmd_i.clear && (clr_q < SLOT_W'(NODES));

    child_we    = cmd_i.clear || (cmd_i.decide && go_pinc && child_zero);
    child_waddr = cmd_i.clear ? clr_q : slot_q;
    child_wdata = cmd_i.clear ? '0 : new_node;

    cnt_waddr  = cmd_i.clear ? clr_q[NODE_W-1:0] : cursor_q;
    pass_re    = cmd_i.decide || cmd_i.fread;
    pass_raddr = cmd_i.decide ? new_node : cursor_q;
    pass_we    = clr_cnt || cmd_i.pinc;
    pass_wdata = cmd_i.clear ? '0 : sat_inc(pass_rd_q);
    end_we     = clr_cnt || (cmd_i.fres && flags_q == FL_NONE && is_ins);
    end_wdata  = cmd_i.clear ? '0 : sat_inc(end_rd_q);

    res_count  = '0;
    res_status = ST_OK;
    unique case (flags_q)
      FL_POOL_FULL: res_status = ST_POOL_FULL;
      FL_BAD_CHAR:  res_status = ST_BAD_CHAR;
      FL_MISS:      res_count  = '0;
      FL_NONE: begin
        if (is_ins) begin
          res_count = '0;
        end else if (op_q == OP_EXACT) begin
          res_count = to_out(end_rd_q);
        end else begin
          res_count = to_out(pass_rd_q);
        end
      end
      default: res_count = '0;
    endcase

    sts_o.clr_last = (clr_q == SLOT_W'(SLOTS - 1));
    sts_o.char_ok  = (flags_q == FL_NONE) && sym_ok_q;
    sts_o.go_pinc  = go_pinc;
    sts_o.last     = last_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // trie storage
  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (cmd_i.lookup) begin
      child_rd_q <= child_mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pass_we) begin
      pass_mem[cnt_waddr] <= pass_wdata;
    end
    if (pass_re) begin
      pass_rd_q <= pass_mem[pass_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_we) begin
      end_mem[cnt_waddr] <= end_wdata;
    end
    if (cmd_i.fread) begin
      end_rd_q <= end_mem[cursor_q];
    end
  end

  // word walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_INSERT;
      start_q     <= 1'b1;
      flags_q     <= FL_NONE;
      cursor_q    <= '0;
      next_free_q <= FREE_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.accept) begin
        start_q <= last_i;
        if (start_q) begin
          op_q     <= op_i;
          cursor_q <= '0;
          flags_q  <= FL_NONE;
        end
      end
      if (cmd_i.lookup && flags_q == FL_NONE && !sym_ok_q) begin
        flags_q <= FL_BAD_CHAR;
      end
      if (cmd_i.decide) begin
        if (is_ins) begin
          if (child_zero && pool_full) begin
            flags_q <= FL_POOL_FULL;
          end else begin
            cursor_q <= new_node;
            if (child_zero) begin
              next_free_q <= next_free_q + 1'b1;
            end
          end
        end else if (child_zero) begin
          flags_q <= FL_MISS;
        end else begin
          cursor_q <= child_rd_q;
        end
      end
      if (cmd_i.fres) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sym_q    <= sym_in.idx;
      sym_ok_q <= sym_in.ok;
      last_q   <= last_i;
    end
    if (cmd_i.lookup) begin
      slot_q <= slot;
    end
    if (cmd_i.fres) begin
      count_q  <= res_count;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule
